FILE: rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// shared concurrent assertion macros, clocked on clk and held off by arst_n
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// expression holds at every edge
`define ASSERT_ALWAYS(name, expr, msg) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (expr)) else $error(msg);

// consequent holds in the same cycle as the antecedent
`define ASSERT_IMPLY(name, ante, cons, msg) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// consequent holds in the cycle after the antecedent
`define ASSERT_NEXT(name, ante, cons, msg) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

FILE: rtl/bbr_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bbr_pkg
// types and constants of the 3x3 rgb box filter
// ----------------------------------------------------------------------------
package bbr_pkg;

	localparam int MAX_SIZE    = 1024;
	localparam int CH_W        = 16;
	localparam int NCH         = 3;
	localparam int PIX_W       = NCH * CH_W;
	localparam int ADDR_W      = $clog2(MAX_SIZE);
	localparam int POS_W       = 10;
	localparam int CFG_W       = 11;
	localparam int SUM_W       = CH_W + 4;
	localparam int PROD_W      = 2 * SUM_W;
	localparam int IN_TDATA_W  = ((PIX_W + 7) / 8) * 8;
	localparam int OUT_FIELD_W = 2 * POS_W + PIX_W;
	localparam int OUT_TDATA_W = ((OUT_FIELD_W + 7) / 8) * 8;

	// one pixel, red in slot 0 (lowest bits)
	typedef logic [NCH-1:0][CH_W-1:0] pix_t;

	// divisor codes: neighbor count of a result
	typedef logic [1:0] div_t;
	localparam div_t DIV_4 = 2'd0;
	localparam div_t DIV_6 = 2'd1;
	localparam div_t DIV_9 = 2'd2;

	// constant division by reciprocal multiply, exact for sums below 9 * 2^16
	localparam logic [SUM_W-1:0] RECIP_6 = SUM_W'(699051);
	localparam int               SHIFT_6 = 22;
	localparam logic [SUM_W-1:0] RECIP_9 = SUM_W'(932068);
	localparam int               SHIFT_9 = 23;
	localparam int               SHIFT_4 = 2;

	// result slots caused by one pixel at (r, c), in emit order
	localparam int NRES     = 4;
	localparam int RES_DIAG = 0;	// (r-1, c-1)
	localparam int RES_UP   = 1;	// (r-1, c) at last column
	localparam int RES_LEFT = 2;	// (r, c-1) on last row
	localparam int RES_SELF = 3;	// (r, c) at last pixel

	// one result between the window stage and the divide stage
	typedef struct packed {
		logic [POS_W-1:0]          row;
		logic [POS_W-1:0]          col;
		logic [NCH-1:0][SUM_W-1:0] sum;
		div_t                      div;
		logic                      run_end;
		logic                      frame_end;
	} res_t;

endpackage

FILE: rtl/bbr_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bbr_ram
// simple dual-port ram, one write and one registered read port
// ----------------------------------------------------------------------------
module bbr_ram #(
	parameter int WIDTH = 48,
	parameter int DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

FILE: rtl/box_blur_3x3_rgb_top.sv
// path: pixel in the stage 1 register, its results via stage 2 to the stage 3 output register
// throughput: one pixel beat per cycle while stage 1 is not held; a pixel that causes k results
//   holds the window stage until all k are emitted (2 at a row end and along the last row,
//   4 at the last pixel): the single result datapath takes one beat per cycle unless stalled
// reset: arst_n clears counters, valids and size (32); no ram clearing pass
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// box_blur_3x3_rgb_top
// streaming 3x3 mean filter over a square rgb image in raster order, with
// two row rams, a two-column window and a constant-reciprocal divide stage
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module box_blur_3x3_rgb_top (
	input  logic                               clk,
	input  logic                               arst_n,
	// size register
	input  logic                               cfg_wr_en,
	input  logic [bbr_pkg::CFG_W-1:0]          cfg_wr_data,
	// pixel beats in
	input  logic                               s_axis_tvalid,
	output logic                               s_axis_tready,
	input  logic [bbr_pkg::IN_TDATA_W-1:0]     s_axis_tdata,	// red_in, green_in, blue_in
	// result beats out
	output logic                               m_axis_tvalid,
	input  logic                               m_axis_tready,
	output logic [bbr_pkg::OUT_TDATA_W-1:0]    m_axis_tdata,	// out_row, out_col, red_out,
									// green_out, blue_out, zero pad
	output logic                               m_axis_tlast,	// run_end
	output logic                               m_axis_tuser	// frame_end
);

	import bbr_pkg::*;

	// ------------------------------------------------------------------
	// configuration and raster position
	// ------------------------------------------------------------------
	logic [ADDR_W-1:0] last_q;	// image side minus one
	logic [ADDR_W-1:0] row_q;
	logic [ADDR_W-1:0] col_q;
	logic [CFG_W-1:0]  size_clamp;

	logic s_accept;
	assign s_accept = s_axis_tvalid && s_axis_tready;

	// out-of-range sizes saturate to the legal range
	always_comb begin
		if (cfg_wr_data < CFG_W'(2)) begin
			size_clamp = CFG_W'(2);
		end else if (cfg_wr_data > CFG_W'(MAX_SIZE)) begin
			size_clamp = CFG_W'(MAX_SIZE);
		end else begin
			size_clamp = cfg_wr_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			last_q <= ADDR_W'(31);
			row_q  <= '0;
			col_q  <= '0;
		end else if (cfg_wr_en) begin
			// new size restarts the image
			last_q <= ADDR_W'(size_clamp - CFG_W'(1));
			row_q  <= '0;
			col_q  <= '0;
		end else if (s_accept) begin
			if (col_q == last_q) begin
				col_q <= '0;
				row_q <= (row_q == last_q) ? '0 : row_q + ADDR_W'(1);
			end else begin
				col_q <= col_q + ADDR_W'(1);
			end
		end
	end

	// ------------------------------------------------------------------
	// stage 1: pixel register, row ram read data, pending result mask
	// ------------------------------------------------------------------
	logic              valid_s1;
	pix_t              pix_s1;
	logic [ADDR_W-1:0] row_s1;
	logic [ADDR_W-1:0] col_s1;
	logic              rfull_s1;	// row r-2 exists
	logic              cfull_s1;	// column c-2 exists
	logic              corner_s1;	// last pixel of the image
	logic [NRES-1:0]   pend_s1;	// results still to emit for this pixel

	pix_t older_rd;	// row r-2 at column c
	pix_t newer_rd;	// row r-1 at column c

	logic            res_ready;	// stage 2 can take a result
	logic            pend_any;
	logic            pend_one;
	logic            emit;
	logic            adv_s1;	// pixel leaves stage 1
	logic [NRES-1:0] pend_load;
	logic [NRES-1:0] sel_mask;

	assign pend_any = (pend_s1 != '0);
	assign pend_one = pend_any && ((pend_s1 & (pend_s1 - NRES'(1))) == '0);
	assign emit     = valid_s1 && pend_any && res_ready;
	assign adv_s1   = valid_s1 && (!pend_any || (pend_one && res_ready));

	// a beat is taken whenever stage 1 is free or drains this cycle
	assign s_axis_tready = !valid_s1 || adv_s1;

	// which results the incoming pixel causes
	always_comb begin
		pend_load           = '0;
		pend_load[RES_DIAG] = (row_q != '0) && (col_q != '0);
		pend_load[RES_UP]   = (row_q != '0) && (col_q == last_q);
		pend_load[RES_LEFT] = (row_q == last_q) && (col_q != '0);
		pend_load[RES_SELF] = (row_q == last_q) && (col_q == last_q);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			pend_s1  <= '0;
		end else if (s_accept) begin
			valid_s1 <= 1'b1;
			pend_s1  <= pend_load;
		end else if (adv_s1) begin
			valid_s1 <= 1'b0;
			pend_s1  <= '0;
		end else if (emit) begin
			pend_s1  <= pend_s1 & ~sel_mask;
		end
	end

	always_ff @(posedge clk) begin
		if (s_accept) begin
			pix_s1    <= s_axis_tdata[PIX_W-1:0];
			row_s1    <= row_q;
			col_s1    <= col_q;
			rfull_s1  <= (row_q >= ADDR_W'(2));
			cfull_s1  <= (col_q >= ADDR_W'(2));
			corner_s1 <= (row_q == last_q) && (col_q == last_q);
		end
	end

	// row rams: read at acceptance, written back as the pixel leaves stage 1
	bbr_ram #(
		.WIDTH (PIX_W),
		.DEPTH (MAX_SIZE)
	) u_older_ram (
		.clk   (clk),
		.we    (adv_s1),
		.waddr (col_s1),
		.wdata (newer_rd),
		.re    (s_accept),
		.raddr (col_q),
		.rdata (older_rd)
	);

	bbr_ram #(
		.WIDTH (PIX_W),
		.DEPTH (MAX_SIZE)
	) u_newer_ram (
		.clk   (clk),
		.we    (adv_s1),
		.waddr (col_s1),
		.wdata (pix_s1),
		.re    (s_accept),
		.raddr (col_q),
		.rdata (newer_rd)
	);

	// two previous columns of rows r-2..r; shift as the pixel leaves
	pix_t win0_q [3];	// column c-2
	pix_t win1_q [3];	// column c-1
	pix_t nb [3][3];	// [column][row] of the 3x3 neighborhood

	always_comb begin
		for (int a = 0; a < 3; a++) begin
			nb[0][a] = win0_q[a];
			nb[1][a] = win1_q[a];
		end
		nb[2][0] = older_rd;
		nb[2][1] = newer_rd;
		nb[2][2] = pix_s1;
	end

	always_ff @(posedge clk) begin
		if (adv_s1) begin
			for (int a = 0; a < 3; a++) begin
				win0_q[a] <= win1_q[a];
				win1_q[a] <= nb[2][a];
			end
		end
	end

	// ------------------------------------------------------------------
	// result select: lowest pending slot, its extent and its sums
	// ------------------------------------------------------------------
	logic              sel_rows3;
	logic              sel_cols3;
	logic [ADDR_W-1:0] sel_row;
	logic [ADDR_W-1:0] sel_col;
	logic [SUM_W-1:0]  colsum [NCH][3];
	logic [NCH-1:0][SUM_W-1:0] sel_sum;
	div_t              sel_div;

	always_comb begin
		sel_mask  = '0;
		sel_rows3 = 1'b0;
		sel_cols3 = 1'b0;
		sel_row   = row_s1;
		sel_col   = col_s1;
		if (pend_s1[RES_DIAG]) begin
			sel_mask[RES_DIAG] = 1'b1;
			sel_rows3 = rfull_s1;
			sel_cols3 = cfull_s1;
			sel_row   = row_s1 - ADDR_W'(1);
			sel_col   = col_s1 - ADDR_W'(1);
		end else if (pend_s1[RES_UP]) begin
			sel_mask[RES_UP] = 1'b1;
			sel_rows3 = rfull_s1;
			sel_row   = row_s1 - ADDR_W'(1);
		end else if (pend_s1[RES_LEFT]) begin
			sel_mask[RES_LEFT] = 1'b1;
			sel_cols3 = cfull_s1;
			sel_col   = col_s1 - ADDR_W'(1);
		end else begin
			sel_mask[RES_SELF] = 1'b1;
		end
	end

	// column sums over two or three rows, then two or three columns
	always_comb begin
		for (int ch = 0; ch < NCH; ch++) begin
			for (int b = 0; b < 3; b++) begin
				colsum[ch][b] = SUM_W'(nb[b][1][ch]) + SUM_W'(nb[b][2][ch])
					+ (sel_rows3 ? SUM_W'(nb[b][0][ch]) : '0);
			end
			sel_sum[ch] = colsum[ch][1] + colsum[ch][2]
				+ (sel_cols3 ? colsum[ch][0] : '0);
		end
	end

	always_comb begin
		if (sel_rows3 && sel_cols3) begin
			sel_div = DIV_9;
		end else if (sel_rows3 || sel_cols3) begin
			sel_div = DIV_6;
		end else begin
			sel_div = DIV_4;
		end
	end

	// ------------------------------------------------------------------
	// stage 2: registered sums, divide by neighbor count
	// ------------------------------------------------------------------
	logic valid_s2;
	res_t res_s2;
	logic out_ready;

	assign res_ready = !valid_s2 || out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (res_ready) begin
			valid_s2 <= emit;
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			res_s2.row       <= POS_W'(sel_row);
			res_s2.col       <= POS_W'(sel_col);
			res_s2.sum       <= sel_sum;
			res_s2.div       <= sel_div;
			res_s2.run_end   <= pend_one;
			res_s2.frame_end <= pend_one && corner_s1;
		end
	end

	logic [SUM_W-1:0]  recip;
	logic [PROD_W-1:0] prod [NCH];
	pix_t              quot;

	assign recip = (res_s2.div == DIV_9) ? RECIP_9 : RECIP_6;

	always_comb begin
		for (int ch = 0; ch < NCH; ch++) begin
			prod[ch] = PROD_W'(res_s2.sum[ch]) * PROD_W'(recip);
			case (res_s2.div)
				DIV_9:   quot[ch] = CH_W'(prod[ch] >> SHIFT_9);
				DIV_6:   quot[ch] = CH_W'(prod[ch] >> SHIFT_6);
				default: quot[ch] = CH_W'(res_s2.sum[ch] >> SHIFT_4);
			endcase
		end
	end

	// ------------------------------------------------------------------
	// stage 3: output register
	// ------------------------------------------------------------------
	logic                   valid_s3;
	logic [OUT_TDATA_W-1:0] data_s3;
	logic                   last_s3;
	logic                   user_s3;

	assign out_ready = !valid_s3 || m_axis_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s3 <= 1'b0;
		end else if (out_ready) begin
			valid_s3 <= valid_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (out_ready && valid_s2) begin
			data_s3 <= OUT_TDATA_W'({quot, res_s2.col, res_s2.row});
			last_s3 <= res_s2.run_end;
			user_s3 <= res_s2.frame_end;
		end
	end

	assign m_axis_tvalid = valid_s3;
	assign m_axis_tdata  = data_s3;
	assign m_axis_tlast  = last_s3;
	assign m_axis_tuser  = user_s3;

	// ------------------------------------------------------------------
	// checks
	// ------------------------------------------------------------------
	`ASSERT_IMPLY(a_pend_needs_pixel, pend_s1 != '0, valid_s1, "results pending with no pixel")
	`ASSERT_IMPLY(a_no_take_midrun, s_accept, !(valid_s1 && pend_any && !pend_one),
		"pixel taken while several results pending")
	`ASSERT_ALWAYS(a_pos_in_image, (row_q <= last_q) && (col_q <= last_q),
		"raster position outside image")
	`ASSERT_NEXT(a_cfg_restart, cfg_wr_en, (row_q == '0) && (col_q == '0),
		"size write did not restart image")
	`ASSERT_IMPLY(a_frame_is_last, m_axis_tvalid && m_axis_tuser, m_axis_tlast,
		"frame end without run end")

endmodule
